[sv/cachk_pkg.sv]
// cachk_pkg: shared types, verdict codes and the CRC32C byte update for the
// cache record checker. No dependencies.
`default_nettype none

package cachk_pkg;

  localparam int unsigned HDR_BYTES = 16;
  localparam int unsigned LEN_W     = 34;

  localparam logic [31:0] MAGIC_RESET = 32'h0000_fefa;
  localparam logic [31:0] CRC_INIT    = 32'hffff_ffff;
  localparam logic [31:0] CRC_POLY    = 32'h82f6_3b78;

  localparam logic [2:0] VERDICT_OK        = 3'd0;
  localparam logic [2:0] VERDICT_SHORT     = 3'd1;
  localparam logic [2:0] VERDICT_LEN       = 3'd2;
  localparam logic [2:0] VERDICT_MAGIC     = 3'd3;
  localparam logic [2:0] VERDICT_CRC       = 3'd4;

  localparam logic [1:0] HW_MAGIC = 2'd0;
  localparam logic [1:0] HW_CRC   = 2'd1;
  localparam logic [1:0] HW_KEY   = 2'd2;
  localparam logic [1:0] HW_VAL   = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [31:0] key_length;
    logic [31:0] value_length;
    logic [31:0] computed_crc;
  } res_t;

  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc,
                                              input logic [7:0]  b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[sv/cachk_in_stage.sv]
// cachk_in_stage: input register for the byte stream.
// Depends on cachk_pkg for the item type.
`default_nettype none

module cachk_in_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [7:0]      in_data_byte,
  input  wire logic            in_last,
  input  wire logic            take,
  output logic                 s1_valid,
  output cachk_pkg::item_t     s1_item
);
  import cachk_pkg::*;

  logic  s1_valid_r, s1_valid_nxt;
  item_t s1_item_r;
  logic  accept;

  assign in_stall = s1_valid_r && !take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= '{data_byte: in_data_byte, last: in_last};
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

`default_nettype wire

[sv/cachk_record.sv]
// cachk_record: per-record state (byte count, header words, running CRC32C)
// and the verdict logic. Depends on cachk_pkg.
`default_nettype none

module cachk_record #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fire,
  input  wire cachk_pkg::item_t item,
  input  wire logic [31:0]      magic,
  output cachk_pkg::res_t       res
);
  import cachk_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

  logic [COUNT_WIDTH-1:0] byte_count_r, byte_count_nxt, count_adv;
  logic [31:0] hdr_magic_r, hdr_magic_nxt, hdr_magic_adv;
  logic [31:0] hdr_crc_r, hdr_crc_nxt, hdr_crc_adv;
  logic [31:0] hdr_key_r, hdr_key_nxt, hdr_key_adv;
  logic [31:0] hdr_val_r, hdr_val_nxt, hdr_val_adv;
  logic [31:0] run_crc_r, run_crc_nxt, run_crc_adv;
  logic        in_hdr;
  logic [1:0]  hw;
  logic [1:0]  lane;
  logic [7:0]  fed;
  logic [31:0] computed;
  logic [LEN_W-1:0] expect_len;
  logic [LEN_W-1:0] count_ext;

  assign in_hdr = byte_count_r < COUNT_WIDTH'(HDR_BYTES);
  assign hw     = byte_count_r[3:2];
  assign lane   = byte_count_r[1:0];

  always_comb begin
    hdr_magic_adv = hdr_magic_r;
    hdr_crc_adv   = hdr_crc_r;
    hdr_key_adv   = hdr_key_r;
    hdr_val_adv   = hdr_val_r;
    fed           = item.data_byte;
    if (in_hdr) begin
      case (hw)
        HW_MAGIC: hdr_magic_adv[lane*8 +: 8] = item.data_byte;
        HW_CRC: begin
          hdr_crc_adv[lane*8 +: 8] = item.data_byte;
          fed = 8'd0;
        end
        HW_KEY:   hdr_key_adv[lane*8 +: 8] = item.data_byte;
        HW_VAL:   hdr_val_adv[lane*8 +: 8] = item.data_byte;
        default:  hdr_val_adv = hdr_val_r;
      endcase
    end
    run_crc_adv = crc32c_byte(run_crc_r, fed);
    count_adv   = (byte_count_r == CountMax) ? byte_count_r
                                             : byte_count_r + COUNT_WIDTH'(1);
  end

  assign computed   = ~run_crc_adv;
  assign expect_len = {2'b00, hdr_key_adv} + {2'b00, hdr_val_adv} + LEN_W'(HDR_BYTES);
  assign count_ext  = LEN_W'(count_adv);

  always_comb begin
    res.key_length   = hdr_key_adv;
    res.value_length = hdr_val_adv;
    res.computed_crc = computed;
    if (count_adv < COUNT_WIDTH'(HDR_BYTES)) begin
      res.verdict = VERDICT_SHORT;
    end else if (expect_len != count_ext) begin
      res.verdict = VERDICT_LEN;
    end else if (hdr_magic_adv != magic) begin
      res.verdict = VERDICT_MAGIC;
    end else if (computed != hdr_crc_adv) begin
      res.verdict = VERDICT_CRC;
    end else begin
      res.verdict = VERDICT_OK;
    end
  end

  always_comb begin
    byte_count_nxt = byte_count_r;
    hdr_magic_nxt  = hdr_magic_r;
    hdr_crc_nxt    = hdr_crc_r;
    hdr_key_nxt    = hdr_key_r;
    hdr_val_nxt    = hdr_val_r;
    run_crc_nxt    = run_crc_r;
    if (fire) begin
      if (item.last) begin
        byte_count_nxt = '0;
        hdr_magic_nxt  = '0;
        hdr_crc_nxt    = '0;
        hdr_key_nxt    = '0;
        hdr_val_nxt    = '0;
        run_crc_nxt    = CRC_INIT;
      end else begin
        byte_count_nxt = count_adv;
        hdr_magic_nxt  = hdr_magic_adv;
        hdr_crc_nxt    = hdr_crc_adv;
        hdr_key_nxt    = hdr_key_adv;
        hdr_val_nxt    = hdr_val_adv;
        run_crc_nxt    = run_crc_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      hdr_magic_r  <= '0;
      hdr_crc_r    <= '0;
      hdr_key_r    <= '0;
      hdr_val_r    <= '0;
      run_crc_r    <= CRC_INIT;
    end else begin
      byte_count_r <= byte_count_nxt;
      hdr_magic_r  <= hdr_magic_nxt;
      hdr_crc_r    <= hdr_crc_nxt;
      hdr_key_r    <= hdr_key_nxt;
      hdr_val_r    <= hdr_val_nxt;
      run_crc_r    <= run_crc_nxt;
    end
  end

`ifndef SYNTHESIS
  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && fire && item.last |=> byte_count_r == '0 && run_crc_r == CRC_INIT)
    else $error("record state not cleared after last word");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && fire && !item.last && byte_count_r != CountMax
      |=> byte_count_r == $past(byte_count_r) + COUNT_WIDTH'(1))
    else $error("byte count did not advance");

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !fire |=> $stable(byte_count_r) && $stable(run_crc_r))
    else $error("record state changed without a word");
`endif

endmodule

`default_nettype wire

[sv/cache_record_checker_core.sv]
// Cache record checker: one byte per cycle. The result word is registered:
// the last byte passes the input register, then the result register, and a
// stalled result can hold it in the input register. Throughput is one byte
// per cycle; a last byte waiting behind a stalled result holds the input stall high.
// Synchronous active-low reset clears the record state, empties both
// registers and sets the expected magic to 0xfefa.
`default_nettype none

module cache_record_checker_core #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_expected_magic,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_verdict,
  output logic [31:0]      out_key_length,
  output logic [31:0]      out_value_length,
  output logic [31:0]      out_computed_crc
);
  import cachk_pkg::*;

  logic [31:0] magic_r;
  logic        s1_valid;
  item_t       s1_item;
  logic        out_free;
  logic        take;
  logic        load;
  res_t        res;
  res_t        out_res_r;
  logic        out_valid_r, out_valid_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= MAGIC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      magic_r <= cfg_expected_magic;
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign take     = s1_valid && (!s1_item.last || out_free);
  assign load     = take && s1_item.last;

  cachk_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last      (in_last),
    .take         (take),
    .s1_valid     (s1_valid),
    .s1_item      (s1_item)
  );

  cachk_record #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_rec (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (take),
    .item  (s1_item),
    .magic (magic_r),
    .res   (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_verdict      = out_res_r.verdict;
  assign out_key_length   = out_res_r.key_length;
  assign out_value_length = out_res_r.value_length;
  assign out_computed_crc = out_res_r.computed_crc;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && load |-> !(out_valid_r && out_stall))
    else $error("result register overwritten while held");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && load |=> out_valid_r)
    else $error("loaded result not presented");

  a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_res_r.verdict <= VERDICT_CRC)
    else $error("verdict code out of range");
`endif

endmodule

`default_nettype wire
